[hw/rtl/sensor_reading_validator_top_defines.svh]
// assertion macros used by the validator rtl
`ifndef SENSOR_READING_VALIDATOR_TOP_DEFINES_SVH
`define SENSOR_READING_VALIDATOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SRV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/srv_pkg.sv]
package srv_pkg;

   // field widths
   localparam int DATA_W  = 16;
   localparam int COUNT_W = 8;
   localparam int DIV_W   = COUNT_W + 1;
   localparam int NUM_W   = DATA_W + COUNT_W + 1;
   localparam int STEP_W  = $clog2(DATA_W);
   localparam int CSR_IDX_W = 2;

   // status codes
   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_JUMP     = 2'd2;
   localparam logic [1:0] STATUS_CLEARED  = 2'd3;

   // opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMUM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAXIMUM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd2;

   typedef struct packed {
      logic              opcode;
      logic [DATA_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [DATA_W-1:0]  current_value;
      logic [DATA_W-1:0]  previous_value;
      logic [DATA_W-1:0]  mean_value;
      logic [COUNT_W-1:0] reading_count;
   } rsp_type;

endpackage

[hw/rtl/sensor_reading_validator_top.sv]
// sequence: a clear or a rejected sample goes from the check step straight to the result;
// an accepted sample runs check, multiply-add, 16 divider steps, then the result
// throughput: one word at a time; the next waits until the result leaves (rsp_stall low);
// the radix-2 restoring divider (one quotient bit per cycle) forms the accepted-sample mean
// reset (synchronous, active high): current, previous and mean go to all ones,
// count to zero, limits to 0 / all ones, tolerance to all ones, no result pending
module sensor_reading_validator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  srv_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output srv_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srv_pkg::DATA_W-1:0]        csr_wdata
);

   import srv_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   state_type           state_ff, state_in;
   logic [DATA_W-1:0]   min_ff, min_in;
   logic [DATA_W-1:0]   max_ff, max_in;
   logic [DATA_W-1:0]   tol_ff, tol_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [DATA_W-1:0]   last_ff, last_in;
   logic [DATA_W-1:0]   mean_ff, mean_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                opcode_ff, opcode_in;
   logic [DATA_W-1:0]   sample_ff, sample_in;
   logic [1:0]          status_ff, status_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [DATA_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [DATA_W-1:0]   diff;
   logic                range_bad;
   logic                jump_bad;
   logic [NUM_W-1:0]    num;
   logic [DIV_W:0]      trial;
   logic                qbit;
   logic [DATA_W-1:0]   quo_next;

   // handshake outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign csr_ready = 1'b1;

   // result word reflects the state after the item
   assign rsp_data.status         = status_ff;
   assign rsp_data.current_value  = value_ff;
   assign rsp_data.previous_value = last_ff;
   assign rsp_data.mean_value     = mean_ff;
   assign rsp_data.reading_count  = count_ff;

   // range and slew checks
   assign range_bad = (sample_ff < min_ff) || (sample_ff > max_ff);
   assign diff      = (sample_ff >= value_ff) ? (sample_ff - value_ff) : (value_ff - sample_ff);
   assign jump_bad  = (count_ff != '0) && (diff > tol_ff);

   // numerator of the running mean
   assign num = NUM_W'(mean_ff) * NUM_W'(count_ff) + NUM_W'(sample_ff);

   // shared divider step: shift in next numerator bit, subtract if it fits
   assign trial    = {rem_ff, quo_ff[DATA_W-1]};
   assign qbit     = (trial >= {1'b0, div_ff});
   assign quo_next = {quo_ff[DATA_W-2:0], qbit};

   // sequencer and datapath next values
   always_comb begin
      state_in  = state_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      tol_in    = tol_ff;
      value_in  = value_ff;
      last_in   = last_ff;
      mean_in   = mean_ff;
      count_in  = count_ff;
      opcode_in = opcode_ff;
      sample_in = sample_ff;
      status_in = status_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;

      // configuration writes, unknown indexes dropped
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MINIMUM:   min_in = csr_wdata;
            CSR_MAXIMUM:   max_in = csr_wdata;
            CSR_TOLERANCE: tol_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               opcode_in = req_data.opcode;
               sample_in = req_data.sample;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (opcode_ff == OP_CLEAR) begin
               mean_in   = '1;
               count_in  = '0;
               status_in = STATUS_CLEARED;
               state_in  = ST_DONE;
            end else if (range_bad) begin
               status_in = STATUS_RANGE;
               state_in  = ST_DONE;
            end else if (jump_bad) begin
               status_in = STATUS_JUMP;
               state_in  = ST_DONE;
            end else begin
               status_in = STATUS_ACCEPTED;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // high part is already below the divisor, so 16 steps give the quotient
            rem_in   = num[NUM_W-1:DATA_W];
            quo_in   = num[DATA_W-1:0];
            div_in   = {1'b0, count_ff} + DIV_W'(1);
            step_in  = STEP_W'(DATA_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = qbit ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
            quo_in = quo_next;
            if (step_ff == '0) begin
               last_in  = value_ff;
               value_in = sample_ff;
               mean_in  = quo_next;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff   <= '0;
         max_ff   <= '1;
         tol_ff   <= '1;
         value_ff <= '1;
         last_ff  <= '1;
         mean_ff  <= '1;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         tol_ff   <= tol_in;
         value_ff <= value_in;
         last_ff  <= last_in;
         mean_ff  <= mean_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      sample_ff <= sample_in;
      status_ff <= status_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
   end

   `include "sensor_reading_validator_top_defines.svh"

   // a clear word shows an empty mean
   `SRV_ASSERT_IMP(a_clear_empties, rsp_valid && rsp_data.status == STATUS_CLEARED, count_ff == '0 && mean_ff == '1, "clear result with nonempty mean")
   // an accepted word leaves at least one reading counted
   `SRV_ASSERT_IMP(a_accept_counts, rsp_valid && rsp_data.status == STATUS_ACCEPTED, count_ff != '0, "accepted result with zero count")
   // divider remainder stays below the divisor
   `SRV_ASSERT_IMP(a_div_rem, state_ff == ST_DIV, rem_ff < div_ff, "divider remainder out of range")
   // last divider step hands over to the result
   `SRV_ASSERT_NXT(a_div_end, state_ff == ST_DIV && step_ff == '0, state_ff == ST_DONE, "divider did not finish")
   // check step goes to multiply or straight to the result
   `SRV_ASSERT_NXT(a_check_exit, state_ff == ST_CHECK, state_ff == ST_MUL || state_ff == ST_DONE, "bad exit from check")

endmodule
